/* rtl/core/csm_pkg.sv */
package csm_pkg;

  typedef enum logic [1:0] {
    CMD_MODE  = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_UP    = 2'd2,
    CMD_DOWN  = 2'd3
  } csm_cmd_t;

  typedef enum logic [2:0] {
    PAGE_CLOCK  = 3'd0,
    PAGE_TIME   = 3'd1,
    PAGE_DATE   = 3'd2,
    PAGE_ALARM  = 3'd3,
    PAGE_TUNE   = 3'd4,
    PAGE_BRIGHT = 3'd5,
    PAGE_FORMAT = 3'd6,
    PAGE_TEMP   = 3'd7
  } csm_page_t;

  localparam int unsigned TUNE_COUNT    = 3;
  localparam int unsigned BRIGHT_LEVELS = 8;
  localparam int unsigned TEMP_MODES    = 3;

  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINUTE_MAX = 8'd59;
  localparam logic [7:0] YEAR_MIN   = 8'd30;
  localparam logic [7:0] YEAR_MAX   = 8'd129;
  localparam logic [7:0] MONTH_MIN  = 8'd1;
  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] DAY_MIN    = 8'd1;
  localparam logic [7:0] TUNE_MAX   = 8'(TUNE_COUNT - 1);
  localparam logic [7:0] BRIGHT_MAX = 8'(BRIGHT_LEVELS - 1);
  localparam logic [7:0] TEMP_MAX   = 8'(TEMP_MODES - 1);

  localparam logic [1:0] ITEM_LAST  = 2'd2;

  // option word bit positions
  localparam int unsigned OPT_H12       = 0;
  localparam int unsigned OPT_BRIGHT_LO = 1;
  localparam int unsigned OPT_BRIGHT_HI = 3;
  localparam int unsigned OPT_TUNE_LO   = 4;
  localparam int unsigned OPT_TUNE_HI   = 5;
  localparam int unsigned OPT_TEMP_LO   = 6;
  localparam int unsigned OPT_TEMP_HI   = 7;
  localparam int unsigned OPT_DAYFIRST  = 8;
  localparam int unsigned OPT_FONT      = 9;

  localparam logic [7:0]  YEAR_RESET    = 8'd21;
  localparam logic [3:0]  MONTH_RESET   = 4'd1;
  localparam logic [4:0]  DAY_RESET     = 5'd1;
  localparam logic [11:0] ALARM_RESET   = {1'b0, 5'd5, 6'd30};
  localparam logic [9:0]  OPTIONS_RESET = {6'd0, BRIGHT_MAX[2:0], 1'b0};

  typedef struct packed {
    logic [1:0] command;
    logic       alarm_sounding;
    logic [7:0] rtc_year;
    logic [3:0] rtc_month;
    logic [4:0] rtc_day;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
  } csm_in_t;

  typedef struct packed {
    csm_page_t   page;
    logic        items_open;
    logic [1:0]  time_item;
    logic [1:0]  date_item;
    logic [1:0]  alarm_item;
    logic        format_item;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        time_dirty;
    logic        date_dirty;
    logic [11:0] alarm_word;
    logic [9:0]  options;
  } csm_state_t;

  typedef struct packed {
    logic [2:0]  page;
    logic        in_items;
    logic [1:0]  item_index;
    logic [4:0]  edit_hour;
    logic [5:0]  edit_minute;
    logic [7:0]  edit_year;
    logic [3:0]  edit_month;
    logic [4:0]  edit_day;
    logic [1:0]  commit;
    logic        alarm_cancel;
    logic [11:0] alarm_setting;
    logic [9:0]  option_word;
  } csm_out_t;

  // wrap inside lo..hi, anything out of range lands on the bound
  function automatic logic [7:0] wrap_step(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi, input logic up);
    if (up) begin
      return (v < lo || v >= hi) ? lo : v + 8'd1;
    end else begin
      return (v <= lo || v > hi) ? hi : v - 8'd1;
    end
  endfunction

  function automatic logic [7:0] days_of(input logic [7:0] y, input logic [3:0] m);
    logic leap;
    leap = (y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd100) && (y != 8'd200);
    case (m)
      4'd2:                     return leap ? 8'd29 : 8'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  return 8'd30;
      default:                  return 8'd31;
    endcase
  endfunction

endpackage

/* rtl/core/csm_ifs.sv */
interface csm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       alarm_sounding;
  logic [7:0] rtc_year;
  logic [3:0] rtc_month;
  logic [4:0] rtc_day;
  logic [4:0] rtc_hour;
  logic [5:0] rtc_minute;

  modport source (
    output valid, command, alarm_sounding, rtc_year, rtc_month, rtc_day, rtc_hour,
           rtc_minute,
    input  ready
  );
  modport sink (
    input  valid, command, alarm_sounding, rtc_year, rtc_month, rtc_day, rtc_hour,
           rtc_minute,
    output ready
  );
endinterface

interface csm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  page;
  logic        in_items;
  logic [1:0]  item_index;
  logic [4:0]  edit_hour;
  logic [5:0]  edit_minute;
  logic [7:0]  edit_year;
  logic [3:0]  edit_month;
  logic [4:0]  edit_day;
  logic [1:0]  commit;
  logic        alarm_cancel;
  logic [11:0] alarm_setting;
  logic [9:0]  option_word;

  modport source (
    output valid, page, in_items, item_index, edit_hour, edit_minute, edit_year,
           edit_month, edit_day, commit, alarm_cancel, alarm_setting, option_word,
    input  ready
  );
  modport sink (
    input  valid, page, in_items, item_index, edit_hour, edit_minute, edit_year,
           edit_month, edit_day, commit, alarm_cancel, alarm_setting, option_word,
    output ready
  );
endinterface

/* rtl/core/csm_step.sv */
module csm_step
  import csm_pkg::*;
(
  input  csm_state_t st,
  input  csm_in_t    ev,
  output csm_state_t st_nxt,
  output csm_out_t   res
);

  logic [7:0] t_hour, t_minute, t_year, t_month, t_day;
  logic [7:0] t_ahour, t_amin, t_tune, t_bright, t_temp;
  logic       up;
  logic       differs;
  logic [1:0] commit;
  logic [1:0] item;

  assign up = (ev.command == CMD_UP);

  // candidate edits, picked by page and item below
  assign t_hour   = wrap_step({3'b0, st.hour}, 8'd0, HOUR_MAX, up);
  assign t_minute = wrap_step({2'b0, st.minute}, 8'd0, MINUTE_MAX, up);
  assign t_year   = wrap_step(st.year, YEAR_MIN, YEAR_MAX, up);
  assign t_month  = wrap_step({4'b0, st.month}, MONTH_MIN, MONTH_MAX, up);
  assign t_day    = wrap_step({3'b0, st.day}, DAY_MIN, days_of(st.year, st.month), up);
  assign t_ahour  = wrap_step({3'b0, st.alarm_word[10:6]}, 8'd0, HOUR_MAX, up);
  assign t_amin   = wrap_step({2'b0, st.alarm_word[5:0]}, 8'd0, MINUTE_MAX, up);
  assign t_tune   = wrap_step({6'b0, st.options[OPT_TUNE_HI:OPT_TUNE_LO]}, 8'd0, TUNE_MAX, up);
  assign t_bright = wrap_step({5'b0, st.options[OPT_BRIGHT_HI:OPT_BRIGHT_LO]}, 8'd0,
                              BRIGHT_MAX, up);
  assign t_temp   = wrap_step({6'b0, st.options[OPT_TEMP_HI:OPT_TEMP_LO]}, 8'd0, TEMP_MAX, up);

  assign differs = (st.year != ev.rtc_year) || (st.month != ev.rtc_month) ||
                   (st.day != ev.rtc_day) || (st.hour != ev.rtc_hour) ||
                   (st.minute != ev.rtc_minute);

  always_comb begin
    st_nxt = st;
    commit = 2'b00;
    if (!ev.alarm_sounding) begin
      case (ev.command)
        CMD_MODE: begin
          st_nxt.items_open = 1'b0;
          st_nxt.page = (st.page == PAGE_TEMP) ? PAGE_CLOCK : csm_page_t'(st.page + 3'd1);
          if (st_nxt.page == PAGE_CLOCK) begin
            if (differs) begin
              commit            = {st.date_dirty, st.time_dirty};
              st_nxt.time_dirty = 1'b0;
              st_nxt.date_dirty = 1'b0;
            end
          end else if (st_nxt.page == PAGE_TIME) begin
            st_nxt.hour   = ev.rtc_hour;
            st_nxt.minute = ev.rtc_minute;
            st_nxt.year   = ev.rtc_year;
            st_nxt.month  = ev.rtc_month;
            st_nxt.day    = ev.rtc_day;
          end
        end
        CMD_ENTER: begin
          if (st.page != PAGE_CLOCK) begin
            if (!st.items_open) begin
              st_nxt.time_item   = 2'd0;
              st_nxt.date_item   = 2'd0;
              st_nxt.alarm_item  = 2'd0;
              st_nxt.format_item = 1'b0;
              st_nxt.items_open  = 1'b1;
            end else begin
              case (st.page)
                PAGE_TIME:   st_nxt.time_item  = (st.time_item >= ITEM_LAST) ? 2'd0
                                                 : st.time_item + 2'd1;
                PAGE_DATE:   st_nxt.date_item  = (st.date_item >= ITEM_LAST) ? 2'd0
                                                 : st.date_item + 2'd1;
                PAGE_ALARM:  st_nxt.alarm_item = (st.alarm_item >= ITEM_LAST) ? 2'd0
                                                 : st.alarm_item + 2'd1;
                PAGE_FORMAT: st_nxt.format_item = ~st.format_item;
                default: ;
              endcase
            end
          end
        end
        default: begin
          case (st.page)
            PAGE_TIME: begin
              if (st.items_open) begin
                case (st.time_item)
                  2'd0: begin
                    st_nxt.hour       = t_hour[4:0];
                    st_nxt.time_dirty = 1'b1;
                  end
                  2'd1: begin
                    st_nxt.minute     = t_minute[5:0];
                    st_nxt.time_dirty = 1'b1;
                  end
                  2'd2: st_nxt.options[OPT_H12] = ~st.options[OPT_H12];
                  default: ;
                endcase
              end
            end
            PAGE_DATE: begin
              if (st.items_open) begin
                case (st.date_item)
                  2'd0: begin
                    st_nxt.year       = t_year;
                    st_nxt.date_dirty = 1'b1;
                  end
                  2'd1: begin
                    st_nxt.month      = t_month[3:0];
                    st_nxt.date_dirty = 1'b1;
                  end
                  2'd2: begin
                    st_nxt.day        = t_day[4:0];
                    st_nxt.date_dirty = 1'b1;
                  end
                  default: ;
                endcase
              end
            end
            PAGE_ALARM: begin
              if (st.items_open) begin
                case (st.alarm_item)
                  2'd0: st_nxt.alarm_word[10:6] = t_ahour[4:0];
                  2'd1: st_nxt.alarm_word[5:0]  = t_amin[5:0];
                  2'd2: st_nxt.alarm_word[11]   = ~st.alarm_word[11];
                  default: ;
                endcase
              end
            end
            PAGE_TUNE:   st_nxt.options[OPT_TUNE_HI:OPT_TUNE_LO] = t_tune[1:0];
            PAGE_BRIGHT: st_nxt.options[OPT_BRIGHT_HI:OPT_BRIGHT_LO] = t_bright[2:0];
            PAGE_FORMAT: begin
              if (st.items_open) begin
                if (!st.format_item) begin
                  st_nxt.options[OPT_DAYFIRST] = ~st.options[OPT_DAYFIRST];
                end else begin
                  st_nxt.options[OPT_FONT] = ~st.options[OPT_FONT];
                end
              end
            end
            PAGE_TEMP:   st_nxt.options[OPT_TEMP_HI:OPT_TEMP_LO] = t_temp[1:0];
            default: ;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    item = 2'd0;
    if (st_nxt.items_open) begin
      case (st_nxt.page)
        PAGE_TIME:   item = st_nxt.time_item;
        PAGE_DATE:   item = st_nxt.date_item;
        PAGE_ALARM:  item = st_nxt.alarm_item;
        PAGE_FORMAT: item = {1'b0, st_nxt.format_item};
        default:     item = 2'd0;
      endcase
    end
  end

  always_comb begin
    res.page          = st_nxt.page;
    res.in_items      = st_nxt.items_open;
    res.item_index    = item;
    res.edit_hour     = st_nxt.hour;
    res.edit_minute   = st_nxt.minute;
    res.edit_year     = st_nxt.year;
    res.edit_month    = st_nxt.month;
    res.edit_day      = st_nxt.day;
    res.commit        = commit;
    res.alarm_cancel  = ev.alarm_sounding;
    res.alarm_setting = st_nxt.alarm_word;
    res.option_word   = st_nxt.options;
  end

endmodule

/* rtl/core/clock_settings_menu_top.sv */
// Settings menu for a clock, driven by one button transaction at a time (mode, enter, up,
// down). Each accepted transaction yields exactly one registered result transaction in the
// cycle after acceptance, carrying the page, item selection, edited time/date, commit request,
// alarm and option words. A new transaction is taken every cycle as long as the single output
// register is empty or being drained, so sustained throughput is one per cycle.
module clock_settings_menu_top
  import csm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  csm_in_if.sink    in_ch,
  csm_out_if.source out_ch
);

  csm_state_t st_r, st_nxt;
  csm_out_t   out_r, res;
  csm_in_t    ev;
  logic       out_valid_r;
  logic       accept;

  assign ev.command        = in_ch.command;
  assign ev.alarm_sounding = in_ch.alarm_sounding;
  assign ev.rtc_year       = in_ch.rtc_year;
  assign ev.rtc_month      = in_ch.rtc_month;
  assign ev.rtc_day        = in_ch.rtc_day;
  assign ev.rtc_hour       = in_ch.rtc_hour;
  assign ev.rtc_minute     = in_ch.rtc_minute;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  csm_step u_step (
    .st     (st_r),
    .ev     (ev),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.page        <= PAGE_CLOCK;
      st_r.items_open  <= 1'b0;
      st_r.time_item   <= 2'd0;
      st_r.date_item   <= 2'd0;
      st_r.alarm_item  <= 2'd0;
      st_r.format_item <= 1'b0;
      st_r.hour        <= 5'd0;
      st_r.minute      <= 6'd0;
      st_r.year        <= YEAR_RESET;
      st_r.month       <= MONTH_RESET;
      st_r.day         <= DAY_RESET;
      st_r.time_dirty  <= 1'b0;
      st_r.date_dirty  <= 1'b0;
      st_r.alarm_word  <= ALARM_RESET;
      st_r.options     <= OPTIONS_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.page          = out_r.page;
  assign out_ch.in_items      = out_r.in_items;
  assign out_ch.item_index    = out_r.item_index;
  assign out_ch.edit_hour     = out_r.edit_hour;
  assign out_ch.edit_minute   = out_r.edit_minute;
  assign out_ch.edit_year     = out_r.edit_year;
  assign out_ch.edit_month    = out_r.edit_month;
  assign out_ch.edit_day      = out_r.edit_day;
  assign out_ch.commit        = out_r.commit;
  assign out_ch.alarm_cancel  = out_r.alarm_cancel;
  assign out_ch.alarm_setting = out_r.alarm_setting;
  assign out_ch.option_word   = out_r.option_word;

endmodule

/* rtl/core/csm_checker.sv */
module csm_checker
  import csm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_page,
  input logic        out_in_items,
  input logic [1:0]  out_item_index,
  input logic [1:0]  out_commit,
  input logic [11:0] out_alarm_setting,
  input logic [9:0]  out_option_word
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_page) &&
      $stable(out_alarm_setting) && $stable(out_option_word))
    else $error("stalled result changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_commit_on_clock_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_commit != 2'b00) |-> out_page == PAGE_CLOCK)
    else $error("commit away from the clock page");

  a_item_needs_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_index != 2'd0) |-> out_in_items)
    else $error("item selected with the list closed");

  a_list_not_on_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_items |-> out_page != PAGE_CLOCK)
    else $error("item list open on the clock page");

endmodule

bind clock_settings_menu_top csm_checker u_csm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_page          (out_ch.page),
  .out_in_items      (out_ch.in_items),
  .out_item_index    (out_ch.item_index),
  .out_commit        (out_ch.commit),
  .out_alarm_setting (out_ch.alarm_setting),
  .out_option_word   (out_ch.option_word)
);

/* bench/tb.sv */
module tb;
  import csm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 170;

  // predicts the screen after each button transaction and checks what comes back
  class menu_scoreboard;
    csm_state_t menu;
    csm_out_t   screens_due[$];
    int         faults;

    function new();
      menu             = '0;
      menu.page        = PAGE_CLOCK;
      menu.year        = YEAR_RESET;
      menu.month       = MONTH_RESET;
      menu.day         = DAY_RESET;
      menu.alarm_word  = ALARM_RESET;
      menu.options     = OPTIONS_RESET;
      faults           = 0;
    endfunction

    static function int unsigned roll(int unsigned v, int unsigned lo, int unsigned hi, bit up);
      if (up) return (v < lo || v >= hi) ? lo : v + 1;
      return (v <= lo || v > hi) ? hi : v - 1;
    endfunction

    static function int unsigned month_length(int unsigned y, int unsigned m);
      if (m < 1 || m > 12) return 31;
      if (m == 2) return (y % 4 == 0 && y % 100 != 0) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function void adjust(bit up);
      logic [4:0] ah;
      logic [5:0] am;
      logic       ae;
      ah = menu.alarm_word[10:6];
      am = menu.alarm_word[5:0];
      ae = menu.alarm_word[11];
      case (menu.page)
        PAGE_TIME: if (menu.items_open) begin
          if (menu.time_item == 2'd0) begin
            menu.hour       = 5'(roll(menu.hour, 0, HOUR_MAX, up));
            menu.time_dirty = 1'b1;
          end else if (menu.time_item == 2'd1) begin
            menu.minute     = 6'(roll(menu.minute, 0, MINUTE_MAX, up));
            menu.time_dirty = 1'b1;
          end else if (menu.time_item == 2'd2) begin
            menu.options[OPT_H12] = ~menu.options[OPT_H12];
          end
        end
        PAGE_DATE: if (menu.items_open) begin
          if (menu.date_item == 2'd0) begin
            menu.year       = 8'(roll(menu.year, YEAR_MIN, YEAR_MAX, up));
            menu.date_dirty = 1'b1;
          end else if (menu.date_item == 2'd1) begin
            menu.month      = 4'(roll(menu.month, MONTH_MIN, MONTH_MAX, up));
            menu.date_dirty = 1'b1;
          end else if (menu.date_item == 2'd2) begin
            menu.day = 5'(roll(menu.day, DAY_MIN, month_length(menu.year, menu.month), up));
            menu.date_dirty = 1'b1;
          end
        end
        PAGE_ALARM: if (menu.items_open) begin
          if (menu.alarm_item == 2'd0) ah = 5'(roll(ah, 0, HOUR_MAX, up));
          else if (menu.alarm_item == 2'd1) am = 6'(roll(am, 0, MINUTE_MAX, up));
          else if (menu.alarm_item == 2'd2) ae = ~ae;
          menu.alarm_word = {ae, ah, am};
        end
        PAGE_TUNE: begin
          menu.options[OPT_TUNE_HI:OPT_TUNE_LO] =
            2'(roll(menu.options[OPT_TUNE_HI:OPT_TUNE_LO], 0, TUNE_MAX, up));
        end
        PAGE_BRIGHT: begin
          menu.options[OPT_BRIGHT_HI:OPT_BRIGHT_LO] =
            3'(roll(menu.options[OPT_BRIGHT_HI:OPT_BRIGHT_LO], 0, BRIGHT_MAX, up));
        end
        PAGE_FORMAT: if (menu.items_open) begin
          if (menu.format_item == 1'b0) menu.options[OPT_DAYFIRST] = ~menu.options[OPT_DAYFIRST];
          else menu.options[OPT_FONT] = ~menu.options[OPT_FONT];
        end
        PAGE_TEMP: begin
          menu.options[OPT_TEMP_HI:OPT_TEMP_LO] =
            2'(roll(menu.options[OPT_TEMP_HI:OPT_TEMP_LO], 0, TEMP_MAX, up));
        end
        default: ;
      endcase
    endfunction

    function void note_press(csm_in_t t);
      csm_out_t   s;
      logic [1:0] commit_bits;
      commit_bits = 2'b00;
      if (!t.alarm_sounding) begin
        case (csm_cmd_t'(t.command))
          CMD_MODE: begin
            menu.items_open = 1'b0;
            menu.page = csm_page_t'(menu.page + 3'd1);
            if (menu.page == PAGE_CLOCK) begin
              // only a real change against the running clock is written back
              if (menu.year != t.rtc_year || menu.month != t.rtc_month || menu.day != t.rtc_day ||
                  menu.hour != t.rtc_hour || menu.minute != t.rtc_minute) begin
                commit_bits     = {menu.date_dirty, menu.time_dirty};
                menu.time_dirty = 1'b0;
                menu.date_dirty = 1'b0;
              end
            end else if (menu.page == PAGE_TIME) begin
              menu.hour   = t.rtc_hour;
              menu.minute = t.rtc_minute;
              menu.year   = t.rtc_year;
              menu.month  = t.rtc_month;
              menu.day    = t.rtc_day;
            end
          end
          CMD_ENTER: if (menu.page != PAGE_CLOCK) begin
            if (!menu.items_open) begin
              menu.time_item   = 2'd0;
              menu.date_item   = 2'd0;
              menu.alarm_item  = 2'd0;
              menu.format_item = 1'b0;
              menu.items_open  = 1'b1;
            end else begin
              case (menu.page)
                PAGE_TIME:   menu.time_item  = (menu.time_item >= ITEM_LAST) ? 2'd0
                                                                            : menu.time_item + 2'd1;
                PAGE_DATE:   menu.date_item  = (menu.date_item >= ITEM_LAST) ? 2'd0
                                                                            : menu.date_item + 2'd1;
                PAGE_ALARM:  menu.alarm_item = (menu.alarm_item >= ITEM_LAST) ? 2'd0
                                                                             : menu.alarm_item + 2'd1;
                PAGE_FORMAT: menu.format_item = ~menu.format_item;
                default: ;
              endcase
            end
          end
          default: adjust(t.command == CMD_UP);
        endcase
      end
      s = '0;
      s.page     = menu.page;
      s.in_items = menu.items_open;
      if (menu.items_open) begin
        case (menu.page)
          PAGE_TIME:   s.item_index = menu.time_item;
          PAGE_DATE:   s.item_index = menu.date_item;
          PAGE_ALARM:  s.item_index = menu.alarm_item;
          PAGE_FORMAT: s.item_index = {1'b0, menu.format_item};
          default: ;
        endcase
      end
      s.edit_hour     = menu.hour;
      s.edit_minute   = menu.minute;
      s.edit_year     = menu.year;
      s.edit_month    = menu.month;
      s.edit_day      = menu.day;
      s.commit        = commit_bits;
      s.alarm_cancel  = t.alarm_sounding;
      s.alarm_setting = menu.alarm_word;
      s.option_word   = menu.options;
      screens_due.push_back(s);
    endfunction

    task flag(string msg);
      faults++;
      if (faults <= 100) $display("mismatch: %s", msg);
    endtask

    task match(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) flag($sformatf("%s got %0h, expected %0h", field, seen, want));
    endtask

    task check_screen(csm_out_t seen);
      csm_out_t want;
      if (screens_due.size() == 0) begin
        flag("result transaction with no press outstanding");
        return;
      end
      want = screens_due.pop_front();
      match("page", want.page, seen.page);
      match("in_items", want.in_items, seen.in_items);
      match("item_index", want.item_index, seen.item_index);
      match("edit_hour", want.edit_hour, seen.edit_hour);
      match("edit_minute", want.edit_minute, seen.edit_minute);
      match("edit_year", want.edit_year, seen.edit_year);
      match("edit_month", want.edit_month, seen.edit_month);
      match("edit_day", want.edit_day, seen.edit_day);
      match("commit", want.commit, seen.commit);
      match("alarm_cancel", want.alarm_cancel, seen.alarm_cancel);
      match("alarm_setting", want.alarm_setting, seen.alarm_setting);
      match("option_word", want.option_word, seen.option_word);
    endtask
  endclass

  logic clk;
  logic rst_n;

  csm_in_if  in_ch();
  csm_out_if out_ch();

  clock_settings_menu_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  menu_scoreboard board = new();

  // running clock as the stimulus sees it, and the page the press stream should be on
  logic [7:0] rtc_y;
  logic [3:0] rtc_m;
  logic [4:0] rtc_d;
  logic [4:0] rtc_h;
  logic [5:0] rtc_min;
  csm_page_t  walk_page;
  int         sent;
  int         send_idle;
  int         sink_stall;
  int         hold_left;
  int         quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off counted down here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  always @(posedge clk) begin : watch
    csm_in_t  t;
    csm_out_t o;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        t.command        = in_ch.command;
        t.alarm_sounding = in_ch.alarm_sounding;
        t.rtc_year       = in_ch.rtc_year;
        t.rtc_month      = in_ch.rtc_month;
        t.rtc_day        = in_ch.rtc_day;
        t.rtc_hour       = in_ch.rtc_hour;
        t.rtc_minute     = in_ch.rtc_minute;
        board.note_press(t);
      end
      if (out_ch.valid && out_ch.ready) begin
        o.page          = out_ch.page;
        o.in_items      = out_ch.in_items;
        o.item_index    = out_ch.item_index;
        o.edit_hour     = out_ch.edit_hour;
        o.edit_minute   = out_ch.edit_minute;
        o.edit_year     = out_ch.edit_year;
        o.edit_month    = out_ch.edit_month;
        o.edit_day      = out_ch.edit_day;
        o.commit        = out_ch.commit;
        o.alarm_cancel  = out_ch.alarm_cancel;
        o.alarm_setting = out_ch.alarm_setting;
        o.option_word   = out_ch.option_word;
        board.check_screen(o);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic press(input csm_cmd_t c, input bit sounding);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= c;
    in_ch.alarm_sounding <= sounding;
    in_ch.rtc_year       <= rtc_y;
    in_ch.rtc_month      <= rtc_m;
    in_ch.rtc_day        <= rtc_d;
    in_ch.rtc_hour       <= rtc_h;
    in_ch.rtc_minute     <= rtc_min;
    if (!sounding && c == CMD_MODE) walk_page = csm_page_t'(walk_page + 3'd1);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drift_rtc();
    if ($urandom_range(99) < 4) begin
      if ($urandom_range(3) == 0) begin
        // anything the port widths allow, out of range included
        rtc_y   = 8'($urandom);
        rtc_m   = 4'($urandom);
        rtc_d   = 5'($urandom);
        rtc_h   = 5'($urandom);
        rtc_min = 6'($urandom);
      end else begin
        rtc_y   = 8'($urandom_range(129));
        rtc_m   = ($urandom_range(3) == 0) ? 4'd2 : 4'($urandom_range(1, 12));
        rtc_d   = 5'($urandom_range(1, 31));
        rtc_h   = 5'($urandom_range(23));
        rtc_min = 6'($urandom_range(59));
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.screens_due.size() != 0) @(posedge clk);
  endtask

  // walk to a page, open its list, fiddle with it, maybe go round to commit
  task automatic menu_session();
    csm_page_t target;
    int        k;
    target = csm_page_t'($urandom_range(7));
    if ($urandom_range(1)) target = csm_page_t'($urandom_range(1, 3));
    while (walk_page != target) begin
      drift_rtc();
      press(CMD_MODE, $urandom_range(99) < 3);
    end
    if (target != PAGE_CLOCK) begin
      if ($urandom_range(99) < 85) press(CMD_ENTER, 1'b0);
      repeat ($urandom_range(1, 14)) begin
        drift_rtc();
        k = $urandom_range(99);
        press(k < 20 ? CMD_ENTER : (k < 60 ? CMD_UP : CMD_DOWN), $urandom_range(99) < 5);
      end
      if ($urandom_range(1)) begin
        while (walk_page != PAGE_CLOCK) begin
          drift_rtc();
          press(CMD_MODE, $urandom_range(99) < 3);
        end
      end
    end
  endtask

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_MODE;
    in_ch.alarm_sounding <= 1'b0;
    in_ch.rtc_year       <= '0;
    in_ch.rtc_month      <= '0;
    in_ch.rtc_day        <= '0;
    in_ch.rtc_hour       <= '0;
    in_ch.rtc_minute     <= '0;
    rst_n                <= 1'b0;
    rtc_y      = 8'd0;
    rtc_m      = 4'd1;
    rtc_d      = 5'd1;
    rtc_h      = 5'd0;
    rtc_min    = 6'd0;
    walk_page  = PAGE_CLOCK;
    sent       = 0;
    send_idle  = 0;
    sink_stall = 0;
    hold_left  = 0;
    quiet      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // clock page ignores enter; a press while sounding only cancels
    press(CMD_ENTER, 1'b0);
    press(CMD_DOWN, 1'b1);
    rtc_y = YEAR_MAX; rtc_m = 4'd12; rtc_d = 5'd31; rtc_h = 5'd23; rtc_min = 6'd59;
    // time page: hour and minute wrap up from the top, 12-hour toggle
    press(CMD_MODE, 1'b0); press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0);
    press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0); press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0);
    // date page: year, month and day wrap
    press(CMD_MODE, 1'b0); press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0);
    press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0); press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0);
    // alarm untouched, tune, brightness from its top, format, temperature down from zero
    press(CMD_MODE, 1'b0); press(CMD_MODE, 1'b0); press(CMD_UP, 1'b0);
    press(CMD_MODE, 1'b0); press(CMD_UP, 1'b0);
    press(CMD_MODE, 1'b0); press(CMD_ENTER, 1'b0); press(CMD_UP, 1'b0);
    press(CMD_MODE, 1'b0); press(CMD_DOWN, 1'b0);
    press(CMD_MODE, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  sink_stall = 0;  end
        1: begin send_idle = 68; sink_stall = 0;  end
        2: begin send_idle = 0;  sink_stall = 68; end
        default: begin send_idle = 12; sink_stall = 12; end
      endcase
      while (sent < 27 + (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          menu_session();
        end else begin
          repeat ($urandom_range(1, 8)) begin
            drift_rtc();
            press(csm_cmd_t'($urandom_range(3)), $urandom_range(99) < 15);
          end
        end
      end
      if (ph == 0) begin
        // output held off while presses keep coming, so the input backs up
        hold_left = 80;
        repeat (12) begin
          drift_rtc();
          press(csm_cmd_t'($urandom_range(3)), 1'b0);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (board.faults == 0 && board.screens_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
